FILE: design/assert_macros.svh
// assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication that is ignored while reset is high.
`define CHK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked implication that is checked in reset as well.
`define CHK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: design/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg: shared types and constants of the SHA-256 hasher
// Item structs, block queue entry, state enums, round constants and the
// SHA-256 sigma functions.
// ----------------------------------------------------------------------------
package sha_pkg;

   localparam int unsigned Q_DEPTH = 2;

   typedef struct packed {
      logic [31:0] data_word;
      logic [2:0]  valid_bytes;
      logic        last_word;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        digest_done;
   } rsp_type;

   // One 512-bit block, word 0 first, and a mark for the closing block.
   typedef struct packed {
      logic [15:0][31:0] words;
      logic              last_blk;
   } blk_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_DATA,
      F_PAD80,
      F_ZERO,
      F_LEN
   } front_state_type;

   typedef enum logic [1:0] {
      C_IDLE,
      C_RUN,
      C_ADD,
      C_OUT
   } core_state_type;

   localparam logic [5:0] PAD_END  = 6'd56;
   localparam logic [7:0] PAD_BYTE = 8'h80;

   function automatic logic [31:0] h_init(input logic [2:0] idx);
      logic [31:0] val;
      unique case (idx)
         3'd0: val = 32'h6a09e667;
         3'd1: val = 32'hbb67ae85;
         3'd2: val = 32'h3c6ef372;
         3'd3: val = 32'ha54ff53a;
         3'd4: val = 32'h510e527f;
         3'd5: val = 32'h9b05688c;
         3'd6: val = 32'h1f83d9ab;
         default: val = 32'h5be0cd19;
      endcase
      return val;
   endfunction

   function automatic logic [31:0] k_const(input logic [5:0] idx);
      logic [31:0] val;
      unique case (idx)
         6'd0:  val = 32'h428a2f98;  6'd1:  val = 32'h71374491;
         6'd2:  val = 32'hb5c0fbcf;  6'd3:  val = 32'he9b5dba5;
         6'd4:  val = 32'h3956c25b;  6'd5:  val = 32'h59f111f1;
         6'd6:  val = 32'h923f82a4;  6'd7:  val = 32'hab1c5ed5;
         6'd8:  val = 32'hd807aa98;  6'd9:  val = 32'h12835b01;
         6'd10: val = 32'h243185be;  6'd11: val = 32'h550c7dc3;
         6'd12: val = 32'h72be5d74;  6'd13: val = 32'h80deb1fe;
         6'd14: val = 32'h9bdc06a7;  6'd15: val = 32'hc19bf174;
         6'd16: val = 32'he49b69c1;  6'd17: val = 32'hefbe4786;
         6'd18: val = 32'h0fc19dc6;  6'd19: val = 32'h240ca1cc;
         6'd20: val = 32'h2de92c6f;  6'd21: val = 32'h4a7484aa;
         6'd22: val = 32'h5cb0a9dc;  6'd23: val = 32'h76f988da;
         6'd24: val = 32'h983e5152;  6'd25: val = 32'ha831c66d;
         6'd26: val = 32'hb00327c8;  6'd27: val = 32'hbf597fc7;
         6'd28: val = 32'hc6e00bf3;  6'd29: val = 32'hd5a79147;
         6'd30: val = 32'h06ca6351;  6'd31: val = 32'h14292967;
         6'd32: val = 32'h27b70a85;  6'd33: val = 32'h2e1b2138;
         6'd34: val = 32'h4d2c6dfc;  6'd35: val = 32'h53380d13;
         6'd36: val = 32'h650a7354;  6'd37: val = 32'h766a0abb;
         6'd38: val = 32'h81c2c92e;  6'd39: val = 32'h92722c85;
         6'd40: val = 32'ha2bfe8a1;  6'd41: val = 32'ha81a664b;
         6'd42: val = 32'hc24b8b70;  6'd43: val = 32'hc76c51a3;
         6'd44: val = 32'hd192e819;  6'd45: val = 32'hd6990624;
         6'd46: val = 32'hf40e3585;  6'd47: val = 32'h106aa070;
         6'd48: val = 32'h19a4c116;  6'd49: val = 32'h1e376c08;
         6'd50: val = 32'h2748774c;  6'd51: val = 32'h34b0bcb5;
         6'd52: val = 32'h391c0cb3;  6'd53: val = 32'h4ed8aa4a;
         6'd54: val = 32'h5b9cca4f;  6'd55: val = 32'h682e6ff3;
         6'd56: val = 32'h748f82ee;  6'd57: val = 32'h78a5636f;
         6'd58: val = 32'h84c87814;  6'd59: val = 32'h8cc70208;
         6'd60: val = 32'h90befffa;  6'd61: val = 32'ha4506ceb;
         6'd62: val = 32'hbef9a3f7;  default: val = 32'hc67178f2;
      endcase
      return val;
   endfunction

   function automatic logic [31:0] big_sig0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sig1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sig0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sig1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
   endfunction

endpackage

FILE: design/sha256_message_hasher_top.sv
// A word is accepted, then its valid bytes, up to four, are packed one per
// cycle while no full block waits for the queue. Each 64-byte block is then
// loaded, run for 64 rounds and folded in the core. The last word adds padding
// and eight digest words; no word is taken while old bytes or a block wait.
// Synchronous reset clears control state and loads the initial hash.
// ----------------------------------------------------------------------------
// sha256_message_hasher_top: SHA-256 message hasher
// Byte packer, block queue and compression core.
// ----------------------------------------------------------------------------
module sha256_message_hasher_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sha_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sha_pkg::rsp_type rsp_data
);

   logic             q_push, q_pop, q_full, q_empty;
   sha_pkg::blk_type q_in, q_out;

   // Front end: packing and padding.
   sha_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_ready (req_ready),
      .q_push    (q_push),
      .q_data    (q_in),
      .q_full    (q_full)
   );

   // Block queue.
   sha_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .pop_data  (q_out),
      .full      (q_full),
      .empty     (q_empty)
   );

   // Back end: compression and digest output.
   sha_core u_core (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_out),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_ready (rsp_ready)
   );

endmodule

FILE: design/sha_front.sv
// ----------------------------------------------------------------------------
// sha_front: byte packer and padder
// Packs the valid bytes of words one per cycle, while no block waits, into
// the block buffer, adds padding and bit length, and feeds the queue.
// ----------------------------------------------------------------------------
module sha_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  sha_pkg::req_type req_data,
   output logic             req_ready,
   output logic             q_push,
   output sha_pkg::blk_type q_data,
   input  logic             q_full
);

   sha_pkg::front_state_type state_ff, state_in;
   logic [31:0]       word_ff, word_in;
   logic [2:0]        nvalid_ff, nvalid_in;
   logic              last_ff, last_in;
   logic [2:0]        k_ff, k_in;
   logic [5:0]        fill_ff, fill_in;
   logic [60:0]       count_ff, count_in;
   logic              pend_ff, pend_in;
   logic              lastblk_ff, lastblk_in;
   logic [15:0][31:0] buf_ff;
   logic [63:0]       len_bits;
   logic [7:0]        byte_val;
   logic              put;
   logic [5:0]        fill_next;
   logic [2:0]        nvalid_clamp;

   assign len_bits  = {count_ff, 3'b000};
   assign put       = (state_ff != sha_pkg::F_IDLE) && !pend_ff;
   assign fill_next = fill_ff + 6'd1;
   assign nvalid_clamp = (req_data.valid_bytes > 3'd4) ? 3'd4 : req_data.valid_bytes;

   assign req_ready = (state_ff == sha_pkg::F_IDLE) && !pend_ff;
   assign q_push    = pend_ff && !q_full;
   assign q_data    = '{words: buf_ff, last_blk: lastblk_ff};

   // Byte that goes into the buffer this cycle.
   always_comb begin
      unique case (state_ff)
         sha_pkg::F_DATA:  byte_val = word_ff[{~k_ff[1:0], 3'b000} +: 8];
         sha_pkg::F_PAD80: byte_val = sha_pkg::PAD_BYTE;
         sha_pkg::F_LEN:   byte_val = len_bits[{~k_ff, 3'b000} +: 8];
         default:          byte_val = 8'h00;
      endcase
   end

   // Next state and bookkeeping.
   always_comb begin
      state_in   = state_ff;
      word_in    = word_ff;
      nvalid_in  = nvalid_ff;
      last_in    = last_ff;
      k_in       = k_ff;
      fill_in    = fill_ff;
      count_in   = count_ff;
      pend_in    = pend_ff;
      lastblk_in = lastblk_ff;
      if (q_push) begin
         pend_in = 1'b0;
      end
      if (state_ff == sha_pkg::F_IDLE) begin
         if (req_valid && req_ready) begin
            word_in   = req_data.data_word;
            nvalid_in = nvalid_clamp;
            last_in   = req_data.last_word;
            k_in      = 3'd0;
            if (nvalid_clamp != 3'd0) begin
               state_in = sha_pkg::F_DATA;
            end else if (req_data.last_word) begin
               state_in = sha_pkg::F_PAD80;
            end
         end
      end else if (put) begin
         fill_in = fill_next;
         if (fill_next == 6'd0) begin
            pend_in    = 1'b1;
            lastblk_in = (state_ff == sha_pkg::F_LEN);
         end
         unique case (state_ff)
            sha_pkg::F_DATA: begin
               count_in = count_ff + 61'd1;
               k_in     = k_ff + 3'd1;
               if (k_ff + 3'd1 == nvalid_ff) begin
                  state_in = last_ff ? sha_pkg::F_PAD80 : sha_pkg::F_IDLE;
               end
            end
            sha_pkg::F_PAD80, sha_pkg::F_ZERO: begin
               k_in     = 3'd0;
               state_in = (fill_next == sha_pkg::PAD_END) ? sha_pkg::F_LEN : sha_pkg::F_ZERO;
            end
            default: begin
               k_in = k_ff + 3'd1;
               if (k_ff == 3'd7) begin
                  state_in = sha_pkg::F_IDLE;
                  count_in = '0;
               end
            end
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha_pkg::F_IDLE;
         fill_ff  <= '0;
         count_ff <= '0;
         pend_ff  <= 1'b0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
         k_ff     <= k_in;
      end
   end

   // Payload registers and the block buffer.
   always_ff @(posedge clock) begin
      word_ff    <= word_in;
      nvalid_ff  <= nvalid_in;
      last_ff    <= last_in;
      lastblk_ff <= lastblk_in;
      if (put) begin
         buf_ff[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] <= byte_val;
      end
   end

endmodule

FILE: design/sha_queue.sv
// ----------------------------------------------------------------------------
// sha_queue: block queue
// Small FIFO of finished blocks between the packer and the compression core.
// ----------------------------------------------------------------------------
module sha_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sha_pkg::blk_type push_data,
   input  logic             pop,
   output sha_pkg::blk_type pop_data,
   output logic             full,
   output logic             empty
);

   localparam int unsigned PW = $clog2(sha_pkg::Q_DEPTH);

   sha_pkg::blk_type mem_ff [sha_pkg::Q_DEPTH];
   logic [PW-1:0]    wr_ff, rd_ff;
   logic [PW:0]      cnt_ff;

   assign full     = (cnt_ff == (PW+1)'(sha_pkg::Q_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rd_ff];

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == PW'(sha_pkg::Q_DEPTH - 1)) ? '0 : wr_ff + PW'(1);
         end
         if (pop) begin
            rd_ff <= (rd_ff == PW'(sha_pkg::Q_DEPTH - 1)) ? '0 : rd_ff + PW'(1);
         end
         cnt_ff <= cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

FILE: design/sha_core.sv
// ----------------------------------------------------------------------------
// sha_core: compression core
// Runs 64 rounds per block, one a cycle, with a rolling 16-word schedule,
// folds the result into the chaining words and emits the digest.
// ----------------------------------------------------------------------------
module sha_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  sha_pkg::blk_type q_data,
   output logic             q_pop,
   output logic             rsp_valid,
   output sha_pkg::rsp_type rsp_data,
   input  logic             rsp_ready
);

   sha_pkg::core_state_type state_ff, state_in;
   logic [15:0][31:0] w_ff;
   logic [7:0][31:0]  v_ff;
   logic [7:0][31:0]  h_ff;
   logic [5:0]        t_ff;
   logic              last_ff;
   logic [2:0]        idx_ff;
   logic [31:0]       w_new, t1, t2, e, a;

   assign a = v_ff[0];
   assign e = v_ff[4];

   // One round and one schedule word.
   always_comb begin
      w_new = w_ff[0] + sha_pkg::small_sig0(w_ff[1]) + w_ff[9] + sha_pkg::small_sig1(w_ff[14]);
      t1 = v_ff[7] + sha_pkg::big_sig1(e) + ((e & v_ff[5]) ^ (~e & v_ff[6]))
         + sha_pkg::k_const(t_ff) + w_ff[0];
      t2 = sha_pkg::big_sig0(a) + ((a & v_ff[1]) ^ (a & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   assign q_pop     = (state_ff == sha_pkg::C_IDLE) && !q_empty;
   assign rsp_valid = (state_ff == sha_pkg::C_OUT);
   assign rsp_data  = '{digest_word: h_ff[idx_ff], word_index: idx_ff,
                        digest_done: (idx_ff == 3'd7)};

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sha_pkg::C_IDLE: if (!q_empty) begin
            state_in = sha_pkg::C_RUN;
         end
         sha_pkg::C_RUN: if (t_ff == 6'd63) begin
            state_in = sha_pkg::C_ADD;
         end
         sha_pkg::C_ADD: begin
            state_in = last_ff ? sha_pkg::C_OUT : sha_pkg::C_IDLE;
         end
         default: if (rsp_ready && idx_ff == 3'd7) begin
            state_in = sha_pkg::C_IDLE;
         end
      endcase
   end

   // Control registers and chaining words.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha_pkg::C_IDLE;
         t_ff     <= '0;
         idx_ff   <= '0;
         for (int i = 0; i < 8; i++) begin
            h_ff[i] <= sha_pkg::h_init(3'(i));
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == sha_pkg::C_RUN) begin
            t_ff <= t_ff + 6'd1;
         end else begin
            t_ff <= '0;
         end
         if (state_ff == sha_pkg::C_ADD) begin
            idx_ff <= '0;
            for (int i = 0; i < 8; i++) begin
               h_ff[i] <= h_ff[i] + v_ff[i];
            end
         end
         if (state_ff == sha_pkg::C_OUT && rsp_ready) begin
            idx_ff <= idx_ff + 3'd1;
            if (idx_ff == 3'd7) begin
               for (int i = 0; i < 8; i++) begin
                  h_ff[i] <= sha_pkg::h_init(3'(i));
               end
            end
         end
      end
   end

   // Working variables and schedule window.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         w_ff    <= q_data.words;
         v_ff    <= h_ff;
         last_ff <= q_data.last_blk;
      end else if (state_ff == sha_pkg::C_RUN) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i+1];
         end
         w_ff[15] <= w_new;
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= e;
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= a;
         v_ff[0] <= t1 + t2;
      end
   end

endmodule

FILE: design/sha_checker.sv
// ----------------------------------------------------------------------------
// sha_checker: port-level checks of the SHA-256 hasher
// Watches the result channel for digest ordering and handshake behavior.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sha_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input sha_pkg::rsp_type rsp_data
);

   `CHK_ALWAYS(a_reset_quiet, clock, $past(reset) |-> !rsp_valid, "result valid right after reset")
   `CHK_RST(a_done_last, clock, reset, rsp_valid |-> (rsp_data.digest_done == (rsp_data.word_index == 3'd7)), "done flag not on word seven")
   `CHK_RST(a_burst, clock, reset, (rsp_valid && rsp_ready && !rsp_data.digest_done) |=> (rsp_valid && rsp_data.word_index == $past(rsp_data.word_index) + 3'd1), "digest words not back to back in order")
   `CHK_RST(a_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)), "stalled item changed")

endmodule

bind sha256_message_hasher_top sha_checker u_sha_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
